@@ design/mca_pkg.sv @@
// Shared types and constants for the assignment solver.
`timescale 1ns / 1ps

package mca_pkg;

    localparam int MAX_SIZE   = 8;
    localparam int IDX_W      = 4;
    localparam int ADDR_W     = 6;
    localparam int DEPTH      = MAX_SIZE * MAX_SIZE;
    localparam int COST_W     = 20;
    localparam int VAL_W      = 32;
    localparam int WIDE_W     = VAL_W + 2;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [IDX_W-1:0]        idx_t;

    localparam val_t PAD_COST  = 32'sd262144;
    localparam val_t SLACK_MAX = 32'sh7fffffff;
    localparam val_t SLACK_MIN = 32'sh80000000;
    localparam idx_t NO_COLUMN = 4'hF;

    typedef logic [MAX_SIZE-1:0][IDX_W-1:0] col_map_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [COST_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        val_t a;
        val_t b;
        val_t c;
        logic neg_b;
    } alu_req_t;

    typedef struct packed {
        logic     done;
        col_map_t col_of_row;
    } solve_stat_t;

endpackage

@@ design/min_cost_assignment_8x8.sv @@
// Top level of the 8x8 minimum-cost assignment solver: loading, solve control, results.
`timescale 1ns / 1ps

// The block takes a cost matrix of up to eight by eight unsigned Q12.8 entries, one beat
// per entry in row-major order, and the sizes are taken from the first beat of a matrix.
// Loading runs at one entry per cycle. The beat marked with tlast starts the solve, during
// which s_tready stays low. The solve uses the shortest augmenting path form of the
// Hungarian method, with every potential and slack update going through one shared
// saturating adder under a small sequencer; each search step does, for each unvisited
// column, a registered cost-store read and then the compare, and each potential update
// walks every column, so the solve time is set by that adder and the single read port of
// the cost store. The matrix is padded to a square: a real row against a missing column
// costs 1024.0, and a missing row costs nothing. One result beat per real row then follows
// in ascending row order, giving the assigned column or -1, with tlast on the last row;
// the next matrix may be loaded once the last result beat has been taken.

module min_cost_assignment_8x8
    import mca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cost [19:0], rows [23:20], columns [27:24], zero fill
    input  logic        s_tlast,   // last entry of the matrix
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // row_index [2:0], assigned_column [6:3], zero fill
    output logic        m_tlast    // result for the last real row
);

    typedef enum logic [2:0] {
        T_LOAD  = 3'b001,
        T_SOLVE = 3'b010,
        T_EMIT  = 3'b100
    } top_state_t;

    top_state_t        state_reg;
    logic [ADDR_W-1:0] pos_reg;
    idx_t              rows_reg, cols_reg;
    logic              start_reg;
    logic [2:0]        row_reg;

    logic        accept;
    idx_t        rows_in, cols_in;
    mem_wr_t     wr;
    solve_stat_t stat;
    logic        last_row;

    // Sizes of zero count as one; anything above the maximum saturates.
    function automatic idx_t clamp_size(input idx_t s);
        if (s == '0)
        begin
            return 4'd1;
        end
        else if (s > IDX_W'(MAX_SIZE))
        begin
            return IDX_W'(MAX_SIZE);
        end
        return s;
    endfunction

    assign s_tready = (state_reg == T_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign rows_in  = clamp_size(s_tdata[23:20]);
    assign cols_in  = clamp_size(s_tdata[27:24]);

    assign wr.en   = accept;
    assign wr.addr = pos_reg;
    assign wr.data = s_tdata[COST_W-1:0];

    mca_solver u_solver
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .start   (start_reg),
        .rows    (rows_reg),
        .columns (cols_reg),
        .stat    (stat)
    );

    assign last_row = ({1'b0, row_reg} == rows_reg - 4'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_LOAD;
            pos_reg   <= '0;
            rows_reg  <= 4'd1;
            cols_reg  <= 4'd1;
            start_reg <= 1'b0;
            row_reg   <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            case (state_reg)
                T_LOAD:
                begin
                    if (accept)
                    begin
                        if (pos_reg == '0)
                        begin
                            rows_reg <= rows_in;
                            cols_reg <= cols_in;
                        end
                        if (s_tlast)
                        begin
                            pos_reg   <= '0;
                            start_reg <= 1'b1;
                            state_reg <= T_SOLVE;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end
                T_SOLVE:
                begin
                    if (stat.done)
                    begin
                        row_reg   <= '0;
                        state_reg <= T_EMIT;
                    end
                end
                T_EMIT:
                begin
                    if (m_tready)
                    begin
                        if (last_row)
                        begin
                            state_reg <= T_LOAD;
                        end
                        else
                        begin
                            row_reg <= row_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= T_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = (state_reg == T_EMIT);
    assign m_tdata  = {1'b0, stat.col_of_row[row_reg], row_reg};
    assign m_tlast  = last_row;

endmodule

@@ design/mca_alu.sv @@
// Shared saturating adder: a plus or minus b, minus c, clipped to 32 bits.
`timescale 1ns / 1ps

module mca_alu
    import mca_pkg::*;
(
    input  alu_req_t req,
    output val_t     res
);

    logic signed [WIDE_W-1:0] b_term;
    logic signed [WIDE_W-1:0] sum;

    always_comb
    begin
        b_term = req.neg_b ? -WIDE_W'(req.b) : WIDE_W'(req.b);
        sum    = WIDE_W'(req.a) + b_term - WIDE_W'(req.c);
        if (sum > WIDE_W'(SLACK_MAX))
        begin
            res = SLACK_MAX;
        end
        else if (sum < WIDE_W'(SLACK_MIN))
        begin
            res = SLACK_MIN;
        end
        else
        begin
            res = sum[VAL_W-1:0];
        end
    end

endmodule

@@ design/mca_solver.sv @@
// Cost store and the sequencer that runs the augmenting-path solve.
`timescale 1ns / 1ps

module mca_solver
    import mca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mem_wr_t     wr,
    input  logic        start,
    input  idx_t        rows,
    input  idx_t        columns,
    output solve_stat_t stat
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_INIT  = 12'b0000_0000_0010,
        S_ROW   = 12'b0000_0000_0100,
        S_STEP  = 12'b0000_0000_1000,
        S_SADDR = 12'b0000_0001_0000,
        S_SCMP  = 12'b0000_0010_0000,
        S_CHECK = 12'b0000_0100_0000,
        S_UPD_A = 12'b0000_1000_0000,
        S_UPD_B = 12'b0001_0000_0000,
        S_AUG   = 12'b0010_0000_0000,
        S_COLL  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    logic [COST_W-1:0] mem [0:DEPTH-1];
    logic [COST_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    state_t   state_reg;
    val_t     u_reg    [0:MAX_SIZE];
    val_t     v_reg    [0:MAX_SIZE];
    val_t     minv_reg [0:MAX_SIZE];
    idx_t     p_reg    [0:MAX_SIZE];
    idx_t     way_reg  [0:MAX_SIZE];
    logic     used_reg [0:MAX_SIZE];
    idx_t     i_reg, j_reg, col0_reg, col1_reg, r0_reg, guard_reg;
    val_t     ur0_reg, delta_reg;
    col_map_t cor_reg;

    idx_t     size;
    idx_t     pr;
    idx_t     prev;
    idx_t     guard_inc;
    val_t     cost_val;
    val_t     new_min;
    alu_req_t alu_req;
    val_t     alu_res;

    assign size      = (rows > columns) ? rows : columns;
    assign guard_inc = guard_reg + 4'd1;
    assign pr        = (p_reg[j_reg] > IDX_W'(MAX_SIZE)) ? '0 : p_reg[j_reg];
    assign prev      = (way_reg[col0_reg] > IDX_W'(MAX_SIZE)) ? '0 : way_reg[col0_reg];

    // Address wraps modulo the store depth, as the row-major index does.
    assign rd_addr = ADDR_W'(ADDR_W'(r0_reg - 4'd1) * ADDR_W'(columns)) +
                     ADDR_W'(j_reg - 4'd1);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        if (r0_reg <= rows && j_reg <= columns)
        begin
            cost_val = VAL_W'(rd_data_reg);
        end
        else if (r0_reg <= rows)
        begin
            cost_val = PAD_COST;
        end
        else
        begin
            cost_val = '0;
        end
    end

    // Operand selection for the one shared adder.
    always_comb
    begin
        alu_req = '{a: cost_val, b: ur0_reg, c: v_reg[j_reg], neg_b: 1'b1};
        case (state_reg)
            S_UPD_A:
            begin
                if (used_reg[j_reg])
                begin
                    alu_req = '{a: u_reg[pr], b: delta_reg, c: '0, neg_b: 1'b0};
                end
                else
                begin
                    alu_req = '{a: minv_reg[j_reg], b: delta_reg, c: '0, neg_b: 1'b1};
                end
            end
            S_UPD_B:
            begin
                alu_req = '{a: v_reg[j_reg], b: delta_reg, c: '0, neg_b: 1'b1};
            end
            default:
            begin
                alu_req = '{a: cost_val, b: ur0_reg, c: v_reg[j_reg], neg_b: 1'b1};
            end
        endcase
    end

    mca_alu u_alu
    (
        .req (alu_req),
        .res (alu_res)
    );

    assign new_min = (alu_res < minv_reg[j_reg]) ? alu_res : minv_reg[j_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    for (int k = 0; k <= MAX_SIZE; k++)
                    begin
                        u_reg[k]   <= '0;
                        v_reg[k]   <= '0;
                        p_reg[k]   <= '0;
                        way_reg[k] <= '0;
                    end
                    i_reg     <= 4'd1;
                    state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    p_reg[0] <= i_reg;
                    for (int k = 0; k <= MAX_SIZE; k++)
                    begin
                        minv_reg[k] <= SLACK_MAX;
                        used_reg[k] <= 1'b0;
                    end
                    col0_reg  <= '0;
                    guard_reg <= '0;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    used_reg[col0_reg] <= 1'b1;
                    r0_reg    <= (p_reg[col0_reg] > IDX_W'(MAX_SIZE)) ? '0 : p_reg[col0_reg];
                    ur0_reg   <= u_reg[(p_reg[col0_reg] > IDX_W'(MAX_SIZE)) ?
                                       '0 : p_reg[col0_reg]];
                    delta_reg <= SLACK_MAX;
                    col1_reg  <= '0;
                    j_reg     <= 4'd1;
                    state_reg <= S_SADDR;
                end
                S_SADDR:
                begin
                    if (j_reg > size)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else if (used_reg[j_reg])
                    begin
                        j_reg <= j_reg + 4'd1;
                    end
                    else
                    begin
                        state_reg <= S_SCMP;
                    end
                end
                S_SCMP:
                begin
                    if (alu_res < minv_reg[j_reg])
                    begin
                        minv_reg[j_reg] <= alu_res;
                        way_reg[j_reg]  <= col0_reg;
                    end
                    if (new_min < delta_reg)
                    begin
                        delta_reg <= new_min;
                        col1_reg  <= j_reg;
                    end
                    j_reg     <= j_reg + 4'd1;
                    state_reg <= S_SADDR;
                end
                S_CHECK:
                begin
                    if (col1_reg == '0)
                    begin
                        guard_reg <= '0;
                        state_reg <= S_AUG;
                    end
                    else
                    begin
                        j_reg     <= '0;
                        state_reg <= S_UPD_A;
                    end
                end
                S_UPD_A:
                begin
                    if (j_reg > size)
                    begin
                        col0_reg <= col1_reg;
                        if (p_reg[col1_reg] != '0 && guard_inc <= size)
                        begin
                            guard_reg <= guard_inc;
                            state_reg <= S_STEP;
                        end
                        else
                        begin
                            guard_reg <= '0;
                            state_reg <= S_AUG;
                        end
                    end
                    else if (used_reg[j_reg])
                    begin
                        u_reg[pr] <= alu_res;
                        state_reg <= S_UPD_B;
                    end
                    else
                    begin
                        minv_reg[j_reg] <= alu_res;
                        j_reg           <= j_reg + 4'd1;
                    end
                end
                S_UPD_B:
                begin
                    v_reg[j_reg] <= alu_res;
                    j_reg        <= j_reg + 4'd1;
                    state_reg    <= S_UPD_A;
                end
                S_AUG:
                begin
                    p_reg[col0_reg] <= p_reg[prev];
                    col0_reg        <= prev;
                    if (prev != '0 && guard_inc <= size)
                    begin
                        guard_reg <= guard_inc;
                    end
                    else if (i_reg >= size)
                    begin
                        j_reg     <= 4'd1;
                        cor_reg   <= {MAX_SIZE{NO_COLUMN}};
                        state_reg <= S_COLL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 4'd1;
                        state_reg <= S_ROW;
                    end
                end
                S_COLL:
                begin
                    if (j_reg > size)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (p_reg[j_reg] != '0 && p_reg[j_reg] <= rows && j_reg <= columns)
                        begin
                            cor_reg[3'(p_reg[j_reg] - 4'd1)] <= j_reg - 4'd1;
                        end
                        j_reg <= j_reg + 4'd1;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.done       = (state_reg == S_DONE);
    assign stat.col_of_row = cor_reg;

endmodule

@@ dv/min_cost_assignment_8x8_tb.sv @@
// Self-checking testbench for the 8x8 minimum-cost assignment solver.
`timescale 1ns / 1ps

module min_cost_assignment_8x8_tb;
    import mca_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [2:0] row;
        logic [3:0] column;
        logic       fin;
    } assignment_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // Predictor state: a copy of the cost store and the held matrix sizes.
    logic [COST_W-1:0] cost_mem [DEPTH];
    bit   [DEPTH-1:0]  cost_written;
    int                load_pos;
    int                rows_held;
    int                cols_held;

    assignment_t       assign_q [$];
    int                error_count;
    int                cycle_count;
    bit                quiet;       // no idling on either side
    int                hold_req;    // cycles for the receiver to hold off

    min_cost_assignment_8x8 u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // cost [19:0], rows [23:20], columns [27:24], zero fill
        .s_tlast  (s_tlast),   // last entry of the matrix
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // row_index [2:0], assigned_column [6:3], zero fill
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int sat32(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return int'(x);
    endfunction

    function automatic int clamp_size(int s);
        if (s == 0)
            return 1;
        return (s > MAX_SIZE) ? MAX_SIZE : s;
    endfunction

    function automatic longint padded_cost(int r, int c);
        if (r <= rows_held && c <= cols_held)
            return longint'(cost_mem[((r - 1) * cols_held + (c - 1)) % DEPTH]);
        return (r <= rows_held) ? longint'(PAD_COST) : 64'sd0;
    endfunction

    // Shortest augmenting path solve; pushes one expected assignment per real row.
    function automatic void solve_assignment();
        int row_pot [MAX_SIZE+1];
        int col_pot [MAX_SIZE+1];
        int row_of  [MAX_SIZE+1];
        int link    [MAX_SIZE+1];
        int slk     [MAX_SIZE+1];
        bit seen    [MAX_SIZE+1];
        int col_of_row [MAX_SIZE];
        int size, col0, col1, r0, pr, prev, guard, delta, cur, p;
        assignment_t a;
        size = (rows_held > cols_held) ? rows_held : cols_held;
        for (int j = 0; j <= MAX_SIZE; j++)
        begin
            row_pot[j] = 0;
            col_pot[j] = 0;
            row_of[j]  = 0;
            link[j]    = 0;
        end
        for (int i = 1; i <= size; i++)
        begin
            col0 = 0;
            guard = 0;
            row_of[0] = i;
            for (int j = 0; j <= MAX_SIZE; j++)
            begin
                slk[j]  = SLACK_MAX;
                seen[j] = 1'b0;
            end
            forever
            begin
                seen[col0] = 1'b1;
                r0 = row_of[col0];
                if (r0 > MAX_SIZE)
                    r0 = 0;
                col1 = 0;
                delta = SLACK_MAX;
                for (int j = 1; j <= size; j++)
                begin
                    if (!seen[j])
                    begin
                        cur = sat32(padded_cost(r0, j) - longint'(row_pot[r0])
                                    - longint'(col_pot[j]));
                        if (cur < slk[j])
                        begin
                            slk[j] = cur;
                            link[j] = col0;
                        end
                        if (slk[j] < delta)
                        begin
                            delta = slk[j];
                            col1 = j;
                        end
                    end
                end
                if (col1 == 0)
                    break;
                for (int j = 0; j <= size; j++)
                begin
                    if (seen[j])
                    begin
                        pr = row_of[j];
                        if (pr > MAX_SIZE)
                            pr = 0;
                        row_pot[pr] = sat32(longint'(row_pot[pr]) + delta);
                        col_pot[j]  = sat32(longint'(col_pot[j]) - delta);
                    end
                    else
                        slk[j] = sat32(longint'(slk[j]) - delta);
                end
                col0 = col1;
                if (row_of[col0] == 0)
                    break;
                guard++;
                if (guard > size)
                    break;
            end
            guard = 0;
            forever
            begin
                prev = link[col0];
                if (prev > MAX_SIZE)
                    prev = 0;
                row_of[col0] = row_of[prev];
                col0 = prev;
                if (col0 == 0)
                    break;
                guard++;
                if (guard > size)
                    break;
            end
        end
        for (int r = 0; r < MAX_SIZE; r++)
            col_of_row[r] = NO_COLUMN;
        for (int j = 1; j <= size; j++)
        begin
            p = row_of[j];
            if (p != 0 && p <= rows_held && j <= cols_held)
                col_of_row[p-1] = j - 1;
        end
        for (int r = 0; r < rows_held; r++)
        begin
            a.row    = r[2:0];
            a.column = col_of_row[r][3:0];
            a.fin    = (r + 1 == rows_held);
            assign_q.push_back(a);
        end
    endfunction

    // Updates the predictor for one accepted entry.
    function automatic void load_entry(logic [19:0] cost, logic [3:0] rows,
                                       logic [3:0] cols, logic last);
        if (load_pos == 0)
        begin
            rows_held = clamp_size(rows);
            cols_held = clamp_size(cols);
        end
        cost_mem[load_pos] = cost;
        cost_written[load_pos] = 1'b1;
        load_pos = (load_pos + 1) % DEPTH;
        if (last)
        begin
            solve_assignment();
            load_pos = 0;
        end
    endfunction

    // Offers one entry, with a random gap in front unless quiet is set, and waits for it to be taken.
    task automatic send_entry(logic [19:0] cost, logic [3:0] rows, logic [3:0] cols,
                              logic last);
        if (!quiet && $urandom_range(99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, cols, rows, cost};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        load_entry(cost, rows, cols, last);
    endtask

    function automatic logic [19:0] pick_cost(int style);
        case (style)
            0: return 20'h0;
            1: return 20'hFFFFF;
            2: return 20'($urandom_range(0, 3));
            default: return 20'($urandom);
        endcase
    endfunction

    // Sends a whole matrix; extra > 0 adds surplus entries, extra < 0 drops some.
    task automatic send_matrix(logic [3:0] rows, logic [3:0] cols, int style, int extra);
        int n;
        n = clamp_size(rows) * clamp_size(cols) + extra;
        for (int k = 0; k < n; k++)
            send_entry(pick_cost(style < 0 ? $urandom_range(0, 3) : style),
                       (k == 0) ? rows : 4'($urandom), (k == 0) ? cols : 4'($urandom),
                       k == n - 1);
    endtask

    // Receiver: random stalls, or a long hold-off when asked for one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_req > 0)
        begin
            m_tready <= 1'b0;
            hold_req <= hold_req - 1;
        end
        else
            m_tready <= quiet || ($urandom_range(99) >= 18);
    end

    // Result checker: every beat is matched against the oldest expected assignment.
    always @(posedge clk)
    begin
        assignment_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (assign_q.size() == 0)
            begin
                $error("unexpected result beat: m_tdata %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = assign_q.pop_front();
                if (m_tdata[2:0] !== want.row)
                begin
                    $error("row_index: expected %0d, got %0d", want.row, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tdata[6:3] !== want.column)
                begin
                    $error("assigned_column: expected %h, got %h", want.column, m_tdata[6:3]);
                    error_count++;
                end
                if (m_tlast !== want.fin)
                begin
                    $error("final_res: expected %b, got %b", want.fin, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("min_cost_assignment_8x8_tb: errors");
            $finish;
        end
    end

    // Corner cases: sizes of one, sizes out of range, saturated costs, ties, padding.
    task automatic test_directed();
        send_matrix(4'd1, 4'd1, 3, 0);
        send_matrix(4'd2, 4'd3, 1, 0);
        send_matrix(4'd3, 4'd2, 3, 0);
        send_matrix(4'd0, 4'd0, 1, 0);
        send_matrix(4'd3, 4'd3, 0, 0);
    endtask

    // Full matrices, one with oversized size fields, sent with no idling at all.
    task automatic test_full_size();
        quiet = 1'b1;
        send_matrix(4'd15, 4'd12, -1, 0);
        send_matrix(4'd8, 4'd8, 2, 0);
        quiet = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering matrices.
    task automatic test_backpressure();
        hold_req = 400;
        send_matrix(4'd4, 4'd4, 3, 0);
        send_matrix(4'd2, 4'd5, 3, 0);
        send_matrix(4'd5, 4'd1, 2, 0);
    endtask

    // Random matrices, mostly small, some with surplus or missing entries.
    task automatic test_random();
        int sent, rr, cc, n, extra, sel;
        bit covered;
        sent = 0;
        while (sent < 20)
        begin
            sel = $urandom_range(99);
            rr = (sel < 80) ? $urandom_range(1, 4) : $urandom_range(0, 15);
            cc = (sel < 80) ? $urandom_range(1, 4) : $urandom_range(0, 15);
            n = clamp_size(rr) * clamp_size(cc);
            extra = 0;
            sel = $urandom_range(99);
            if (sel < 10 && n + 3 < DEPTH)
                extra = $urandom_range(1, 3);
            else if (sel < 20 && n > 1)
            begin
                extra = -$urandom_range(1, n - 1);
                // A short matrix must only read entries written earlier.
                covered = 1'b1;
                for (int k = 0; k < n; k++)
                    if (!cost_written[k])
                        covered = 1'b0;
                if (!covered)
                    extra = 0;
            end
            send_matrix(4'(rr), 4'(cc), -1, extra);
            sent += n + extra;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        load_pos = 0;
        rows_held = 1;
        cols_held = 1;
        cost_written = '0;
        error_count = 0;
        cycle_count = 0;
        quiet = 1'b0;
        hold_req = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_size();
        test_backpressure();
        test_random();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        while (assign_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("min_cost_assignment_8x8_tb: clean");
        else
            $display("min_cost_assignment_8x8_tb: errors");
        $finish;
    end

endmodule
